FILE: sv/mcst_pkg.sv
package mcst_pkg;

   localparam int NUM_CHANNELS_DEF = 16;

   localparam int TICK_W = 32;
   localparam int FUNC_W = 3;
   localparam int CHAN_W = 8;

   localparam logic [TICK_W-1:0] MIN_TIMEOUT_RST = 32'd1;

   // one table entry: {repeat, start_tick, period}
   localparam int ENTRY_W    = 2 * TICK_W + 1;
   localparam int PERIOD_LSB = 0;
   localparam int START_LSB  = TICK_W;
   localparam int REPEAT_BIT = 2 * TICK_W;

   localparam logic [ENTRY_W-1:0] MASK_REPEAT = {1'b1, {TICK_W{1'b0}}, {TICK_W{1'b0}}};
   localparam logic [ENTRY_W-1:0] MASK_START  = {1'b0, {TICK_W{1'b1}}, {TICK_W{1'b0}}};
   localparam logic [ENTRY_W-1:0] MASK_PERIOD = {1'b0, {TICK_W{1'b0}}, {TICK_W{1'b1}}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CHECK    = 3'd0,
      FUNC_CREATE   = 3'd1,
      FUNC_START    = 3'd2,
      FUNC_STOP     = 3'd3,
      FUNC_STOP_ALL = 3'd4,
      FUNC_CHANGE   = 3'd5
   } func_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

FILE: sv/mcst_ram.sv
module mcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [WIDTH-1:0] wr_mask,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // per-bit write enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < WIDTH; b++) begin
            if (wr_mask[b]) begin
               mem_ff[wr_addr][b] <= wr_data[b];
            end
         end
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/multi_channel_soft_timer.sv
// create, start, stop, stop all and change period register their result in the output
//   register or the pending slot; check gives it when its scan finds an expiry or ends
// throughput: non-check requests one per cycle while results drain; a check holds the
//   block for its scan, one table read per channel through the single read port
// reset clears allocated, running and all handshake state, sets min_timeout to
//   1; the table ram is not cleared, since every entry is written before it is used
module multi_channel_soft_timer #(
   parameter int NUM_CHANNELS = mcst_pkg::NUM_CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mcst_pkg::FUNC_W-1:0] req_func,
   input  logic [mcst_pkg::CHAN_W-1:0] req_channel,
   input  logic                        req_repeat_mode,
   input  logic [mcst_pkg::TICK_W-1:0] req_ticks,
   input  logic [mcst_pkg::TICK_W-1:0] req_now,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic                        rsp_expired,
   output logic [mcst_pkg::CHAN_W-1:0] rsp_expired_channel,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [mcst_pkg::TICK_W-1:0] csr_data
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W = IDX_W + 1;
   localparam int EW    = mcst_pkg::ENTRY_W;
   localparam int TW    = mcst_pkg::TICK_W;

   localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(NUM_CHANNELS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);
   localparam logic [mcst_pkg::CHAN_W:0] CH_LIM = (mcst_pkg::CHAN_W + 1)'(NUM_CHANNELS);

   // control state
   mcst_pkg::state_type state_ff, state_in;
   logic [NUM_CHANNELS-1:0] alloc_ff, alloc_in;
   logic [NUM_CHANNELS-1:0] run_ff, run_in;
   logic [TW-1:0]           min_timeout_ff, min_timeout_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                    ev_valid_ff, ev_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pend_valid_ff, pend_valid_in;

   // payload
   logic [IDX_W-1:0]        ev_idx_ff, ev_idx_in;
   logic [TW-1:0]           now_ff, now_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [mcst_pkg::CHAN_W-1:0] rsp_ch_ff, rsp_ch_in;
   logic                    pend_status_ff, pend_status_in;
   logic                    pend_hit_ff, pend_hit_in;
   logic [mcst_pkg::CHAN_W-1:0] pend_ch_ff, pend_ch_in;

   // table ram
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [EW-1:0]    wr_data;
   logic [EW-1:0]    wr_mask;
   logic [IDX_W-1:0] rd_addr;
   logic [EW-1:0]    rd_data;

   mcst_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic                    req_fire;
   logic                    in_range;
   logic [IDX_W-1:0]        req_idx;
   logic                    res_load;
   logic                    res_status;
   logic                    res_hit;
   logic [mcst_pkg::CHAN_W-1:0] res_ch;
   logic [TW-1:0]           rd_start;
   logic [TW-1:0]           rd_period;
   logic                    rd_repeat;
   logic [TW-1:0]           elapsed;
   logic                    ev_hit;
   logic                    out_free;

   assign req_ready = (state_ff == mcst_pkg::ST_IDLE) && !pend_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign in_range  = {1'b0, req_channel} < CH_LIM;
   assign req_idx   = req_channel[IDX_W-1:0];

   assign rd_start  = rd_data[mcst_pkg::START_LSB +: TW];
   assign rd_period = rd_data[mcst_pkg::PERIOD_LSB +: TW];
   assign rd_repeat = rd_data[mcst_pkg::REPEAT_BIT];
   assign elapsed   = now_ff - rd_start;
   assign ev_hit    = alloc_ff[ev_idx_ff] && run_ff[ev_idx_ff] && (elapsed >= rd_period);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      alloc_in       = alloc_ff;
      run_in         = run_ff;
      min_timeout_in = min_timeout_ff;
      rd_ptr_in      = rd_ptr_ff;
      ev_valid_in    = 1'b0;
      ev_idx_in      = ev_idx_ff;
      now_in         = now_ff;
      wr_en          = 1'b0;
      wr_addr        = req_idx;
      wr_data        = {req_repeat_mode, req_now, req_ticks};
      wr_mask        = '0;
      rd_addr        = rd_ptr_ff[IDX_W-1:0];
      res_load       = 1'b0;
      res_status     = 1'b1;
      res_hit        = 1'b0;
      res_ch         = '0;

      if (csr_valid && csr_ready) begin
         min_timeout_in = csr_data;
      end

      case (state_ff)
         mcst_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_load = 1'b1;
               case (mcst_pkg::func_type'(req_func))
                  mcst_pkg::FUNC_CHECK: begin
                     res_load  = 1'b0;
                     state_in  = mcst_pkg::ST_SCAN;
                     rd_ptr_in = '0;
                     now_in    = req_now;
                  end
                  mcst_pkg::FUNC_CREATE: begin
                     if (in_range && !alloc_ff[req_idx]) begin
                        alloc_in[req_idx] = 1'b1;
                        run_in[req_idx]   = 1'b0;
                        wr_en             = 1'b1;
                        wr_mask           = mcst_pkg::MASK_REPEAT;
                        res_status        = 1'b0;
                     end
                  end
                  mcst_pkg::FUNC_START: begin
                     if (in_range && alloc_ff[req_idx] && req_ticks >= min_timeout_ff) begin
                        run_in[req_idx] = 1'b1;
                        wr_en           = 1'b1;
                        wr_mask         = mcst_pkg::MASK_START | mcst_pkg::MASK_PERIOD;
                        res_status      = 1'b0;
                     end
                  end
                  mcst_pkg::FUNC_STOP: begin
                     if (in_range && alloc_ff[req_idx]) begin
                        run_in[req_idx] = 1'b0;
                        res_status      = 1'b0;
                     end
                  end
                  mcst_pkg::FUNC_STOP_ALL: begin
                     run_in     = run_ff & ~alloc_ff;
                     res_status = 1'b0;
                  end
                  mcst_pkg::FUNC_CHANGE: begin
                     if (in_range) begin
                        wr_en      = 1'b1;
                        wr_data    = {req_repeat_mode, req_now, {16'd0, req_ticks[15:0]}};
                        wr_mask    = mcst_pkg::MASK_PERIOD;
                        res_status = 1'b0;
                     end
                  end
                  default: begin
                     res_status = 1'b1;
                  end
               endcase
            end
         end
         mcst_pkg::ST_SCAN: begin
            // read of the next entry overlaps the compare of the current one
            if (rd_ptr_ff < PTR_END) begin
               rd_ptr_in   = rd_ptr_ff + PTR_W'(1);
               ev_valid_in = 1'b1;
               ev_idx_in   = rd_ptr_ff[IDX_W-1:0];
            end
            if (ev_valid_ff) begin
               if (ev_hit) begin
                  res_load    = 1'b1;
                  res_status  = 1'b0;
                  res_hit     = 1'b1;
                  res_ch      = mcst_pkg::CHAN_W'(ev_idx_ff);
                  state_in    = mcst_pkg::ST_IDLE;
                  ev_valid_in = 1'b0;
                  if (rd_repeat) begin
                     wr_en   = 1'b1;
                     wr_addr = ev_idx_ff;
                     wr_data = {rd_repeat, now_ff, rd_period};
                     wr_mask = mcst_pkg::MASK_START;
                  end else begin
                     run_in[ev_idx_ff] = 1'b0;
                  end
               end else if (ev_idx_ff == IDX_LAST) begin
                  res_load    = 1'b1;
                  res_status  = 1'b0;
                  state_in    = mcst_pkg::ST_IDLE;
                  ev_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = mcst_pkg::ST_IDLE;
         end
      endcase

      // output register with one pending slot behind it
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_ch_in      = rsp_ch_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_hit_in    = pend_hit_ff;
      pend_ch_in     = pend_ch_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = pend_status_ff;
            rsp_hit_in    = pend_hit_ff;
            rsp_ch_in     = pend_ch_ff;
            pend_valid_in = 1'b0;
         end else if (res_load) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status;
            rsp_hit_in    = res_hit;
            rsp_ch_in     = res_ch;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (res_load) begin
         pend_valid_in  = 1'b1;
         pend_status_in = res_status;
         pend_hit_in    = res_hit;
         pend_ch_in     = res_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mcst_pkg::ST_IDLE;
         alloc_ff       <= '0;
         run_ff         <= '0;
         min_timeout_ff <= mcst_pkg::MIN_TIMEOUT_RST;
         rd_ptr_ff      <= '0;
         ev_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alloc_ff       <= alloc_in;
         run_ff         <= run_in;
         min_timeout_ff <= min_timeout_in;
         rd_ptr_ff      <= rd_ptr_in;
         ev_valid_ff    <= ev_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_valid_ff  <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff      <= ev_idx_in;
      now_ff         <= now_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_ch_ff      <= rsp_ch_in;
      pend_status_ff <= pend_status_in;
      pend_hit_ff    <= pend_hit_in;
      pend_ch_ff     <= pend_ch_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_expired         = rsp_hit_ff;
   assign rsp_expired_channel = rsp_ch_ff;

   // the pending slot only fills behind a held output beat
   a_pend_behind_out : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending result without an output beat");

   a_no_accept_in_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcst_pkg::ST_SCAN) |-> !req_ready)
      else $error("request accepted during a scan");

   a_expired_in_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired) |-> ({1'b0, rsp_expired_channel} < CH_LIM))
      else $error("expired channel out of range");

   a_single_shot_stops : assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcst_pkg::ST_SCAN && ev_valid_ff && ev_hit && !rd_repeat)
         |=> !run_ff[$past(ev_idx_ff)])
      else $error("single-shot channel still running after expiry");

endmodule
